// ----- sv/bus_trace_ring_buffer_assert.svh -----
// Assertion macros shared by the trace buffer modules.
`ifndef BUS_TRACE_RING_BUFFER_ASSERT_SVH
`define BUS_TRACE_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTRB_ASSERT_IMPL(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTRB_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/btrb_pkg.sv -----
// Types, codes and constants of the bus trace ring buffer.
package btrb_pkg;

	localparam int TRACE_DEPTH_DEF = 1024;
	localparam int CFG_W           = 11;
	localparam int APB_DATA_W      = 32;
	localparam int APB_ADDR_W      = 3;

	// Register index, taken from the word address bit of paddr.
	localparam logic REG_IDX_DEPTH = 1'b0;

	// Action codes.
	localparam logic [2:0] ACT_ADD        = 3'd0;
	localparam logic [2:0] ACT_SET_OPCODE = 3'd1;
	localparam logic [2:0] ACT_SET_REGS   = 3'd2;
	localparam logic [2:0] ACT_READ       = 3'd3;
	localparam logic [2:0] ACT_CLEAR      = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_MODIFY
	} state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] cycle_stamp;
		logic [3:0]  event_kind;
		logic [2:0]  event_source;
		logic [3:0]  event_target;
		logic [15:0] bus_address;
		logic [7:0]  bus_data;
		logic [23:0] opcode_bytes;
		logic [39:0] register_bundle;
		logic [9:0]  age;
	} item_t;

	typedef struct packed {
		logic [31:0] out_cycle;
		logic [3:0]  out_kind;
		logic [2:0]  out_source;
		logic [3:0]  out_target;
		logic [15:0] out_address;
		logic [7:0]  out_data;
		logic [23:0] out_opcode;
		logic        opcode_valid;
		logic [39:0] out_registers;
		logic        registers_valid;
		logic [10:0] stored_count;
		logic        in_range;
	} result_t;

	// One ring entry as held in the memory.
	typedef struct packed {
		logic [31:0] cycle;
		logic [3:0]  kind;
		logic [2:0]  source;
		logic [3:0]  target;
		logic [15:0] address;
		logic [7:0]  data;
		logic [23:0] opcode;
		logic        opcode_valid;
		logic [39:0] registers;
		logic        registers_valid;
	} entry_t;

endpackage

// ----- sv/btrb_store.sv -----
// Entry memory of the trace ring: one write port, one registered read port.
module btrb_store
	import btrb_pkg::*;
#(
	parameter int TRACE_DEPTH = TRACE_DEPTH_DEF,
	localparam int AW = $clog2(TRACE_DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t ring_q [TRACE_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= ring_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/btrb_ctrl.sv -----
// Cursor and count keeping, entry addressing and read-modify-write sequencing.
`include "bus_trace_ring_buffer_assert.svh"
module btrb_ctrl
	import btrb_pkg::*;
#(
	parameter int TRACE_DEPTH = TRACE_DEPTH_DEF,
	localparam int AW = $clog2(TRACE_DEPTH),
	localparam int CW = $clog2(TRACE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  item_t            item,
	input  logic [CFG_W-1:0] active_depth,
	output logic             busy,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  entry_t           rd_data,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output entry_t           wr_data,
	output logic             res_valid,
	output result_t          res
);

	// Wide enough for cursor plus depth and for the age field.
	localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

	state_t        state_q, state_d;
	logic [AW-1:0] cursor_q;
	logic [CW-1:0] total_q;

	logic [CW-1:0] depth_eff;
	logic [AW-1:0] cur_eff;
	logic [CW-1:0] cnt_eff;
	logic [CW-1:0] cur_inc;
	logic [SW-1:0] back_w;
	logic [SW-1:0] cur_w;
	logic [SW-1:0] idx_w;
	logic [AW-1:0] idx;
	logic          hit;
	logic          accept;

	logic [2:0]    action_s1;
	logic          hit_s1;
	logic [AW-1:0] idx_s1;
	item_t         item_s1;

	entry_t        entry;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Depth clamped to the legal range, cursor and count seen against it.
	always_comb begin
		if (active_depth == '0) begin
			depth_eff = CW'(1);
		end else if (32'(active_depth) > 32'(TRACE_DEPTH)) begin
			depth_eff = CW'(TRACE_DEPTH);
		end else begin
			depth_eff = CW'(active_depth);
		end
		cur_eff = (CW'(cursor_q) < depth_eff) ? cursor_q : '0;
		cnt_eff = (total_q < depth_eff) ? total_q : depth_eff;
		cur_inc = CW'(cur_eff) + CW'(1);
	end

	// Entry that lies a given distance back from the newest one, wrapping once; add addresses the cursor entry.
	always_comb begin
		back_w = (item.action == ACT_READ) ? SW'(item.age) : '0;
		cur_w  = SW'(cur_eff);
		if (cur_w > back_w) begin
			idx_w = cur_w - SW'(1) - back_w;
		end else begin
			idx_w = cur_w + SW'(depth_eff) - SW'(1) - back_w;
		end
		idx = idx_w[AW-1:0];
		hit = 1'b0;
		case (item.action)
			ACT_ADD: begin
				hit = 1'b1;
				idx = cur_eff;
			end
			ACT_SET_OPCODE, ACT_SET_REGS: hit = (cnt_eff != '0);
			ACT_READ:                     hit = (SW'(item.age) < SW'(cnt_eff));
			default:                      hit = 1'b0;
		endcase
	end

	assign rd_en   = accept;
	assign rd_addr = idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= '0;
			total_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (item.action)
					ACT_ADD: begin
						cursor_q <= (cur_inc == depth_eff) ? '0 : cur_inc[AW-1:0];
						total_q  <= (cnt_eff < depth_eff) ? cnt_eff + CW'(1) : depth_eff;
					end
					ACT_CLEAR: begin
						cursor_q <= '0;
						total_q  <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= item.action;
			hit_s1    <= hit;
			idx_s1    <= idx;
			item_s1   <= item;
		end
	end

	// The entry read at accept is merged with the transaction and, for add or a set that hits, written back.
	always_comb begin
		state_d   = state_q;
		entry     = rd_data;
		wr_en     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				state_d   = ST_IDLE;
				res_valid = 1'b1;
				case (action_s1)
					ACT_ADD: begin
						entry.cycle           = item_s1.cycle_stamp;
						entry.kind            = item_s1.event_kind;
						entry.source          = item_s1.event_source;
						entry.target          = item_s1.event_target;
						entry.address         = item_s1.bus_address;
						entry.data            = item_s1.bus_data;
						entry.opcode          = '0;
						entry.opcode_valid    = 1'b0;
						entry.registers       = '0;
						entry.registers_valid = 1'b0;
						wr_en                 = 1'b1;
					end
					ACT_SET_OPCODE: begin
						entry.opcode       = item_s1.opcode_bytes;
						entry.opcode_valid = 1'b1;
						wr_en              = hit_s1;
					end
					ACT_SET_REGS: begin
						entry.registers       = item_s1.register_bundle;
						entry.registers_valid = 1'b1;
						wr_en                 = hit_s1;
					end
					default: begin
					end
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign wr_addr = idx_s1;
	assign wr_data = entry;

	always_comb begin
		res = '0;
		if (hit_s1) begin
			res.out_cycle       = entry.cycle;
			res.out_kind        = entry.kind;
			res.out_source      = entry.source;
			res.out_target      = entry.target;
			res.out_address     = entry.address;
			res.out_data        = entry.data;
			res.out_opcode      = entry.opcode_valid ? entry.opcode : '0;
			res.opcode_valid    = entry.opcode_valid;
			res.out_registers   = entry.registers_valid ? entry.registers : '0;
			res.registers_valid = entry.registers_valid;
			res.in_range        = 1'b1;
		end
		res.stored_count = 11'(total_q);
	end

	`BTRB_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "accepted transaction did not go busy")
	`BTRB_ASSERT_NEXT(a_one_modify, clk, arst_n, busy, !busy, "modify step lasted more than one cycle")
	`BTRB_ASSERT_IMPL(a_total_bound, clk, arst_n, 1'b1, 32'(total_q) <= 32'(TRACE_DEPTH), "sample count beyond ring depth")
	`BTRB_ASSERT_IMPL(a_write_busy, clk, arst_n, wr_en, busy && hit_s1, "memory written outside a hit modify step")

endmodule

// ----- sv/bus_trace_ring_buffer.sv -----
// Top level of the bus trace ring buffer: register port, controller, memory, result register.
//
// Bus events are captured into a ring of TRACE_DEPTH entries held in one synchronous memory.
// A transaction is accepted on a rising edge where start is high and busy is low; the item
// port carries the action and its operands. Add stores a sample at the write cursor, the two
// set actions attach opcode bytes or CPU registers to the newest sample, read returns the
// sample a given age back from the newest, and clear empties the ring.
// Every transaction gives exactly one result: done is registered from the modify step and
// stays high for one cycle, with the touched entry on the result port. The result is taken
// at the edge that ends that cycle; the receiver cannot stall. A transaction is not accepted
// while another is in progress: the accepting edge reads the entry, the following cycle
// merges it and, for add or a set that hits, writes it back via the single memory write
// port; busy is high that cycle so that no read can overtake the pending write. The active
// depth lives in the APB register at byte address 0 and should be written only while the
// ring is idle, followed by a clear. Reset empties the ring and sets the active depth to
// TRACE_DEPTH, capped at 2047; memory contents are not cleared, as no read can reach an
// entry that has not been written since the last clear.
`include "bus_trace_ring_buffer_assert.svh"
module bus_trace_ring_buffer
	import btrb_pkg::*;
#(
	parameter int TRACE_DEPTH = TRACE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  start,
	input  item_t                 item,
	output logic                  busy,
	output logic                  done,
	output result_t               result
);

	localparam int AW = $clog2(TRACE_DEPTH);
	// Reset depth, limited to what the eleven-bit register can hold.
	localparam int DEPTH_RESET = (TRACE_DEPTH > 2047) ? 2047 : TRACE_DEPTH;

	logic [CFG_W-1:0] depth_q;
	logic             reg_write;

	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	entry_t           rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	entry_t           wr_data;
	logic             res_valid;
	result_t          res;

	logic             done_q;
	result_t          result_q;

	// The register port never inserts wait states.
	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1] == REG_IDX_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= CFG_W'(DEPTH_RESET);
		end else if (reg_write) begin
			depth_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[APB_ADDR_W-1] == REG_IDX_DEPTH) ? APB_DATA_W'(depth_q) : '0;

	btrb_ctrl #(
		.TRACE_DEPTH (TRACE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.active_depth (depth_q),
		.busy         (busy),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.res_valid    (res_valid),
		.res          (res)
	);

	btrb_store #(
		.TRACE_DEPTH (TRACE_DEPTH)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Result register: the strobe is cleared by reset, the payload is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			result_q <= res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`BTRB_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy, "result strobe while still busy")
	`BTRB_ASSERT_IMPL(a_done_after_busy, clk, arst_n, done, $past(busy),
		"result without a modify step")
	`BTRB_ASSERT_IMPL(a_miss_empty, clk, arst_n, done && !result.in_range,
		(result.out_cycle == '0) && !result.opcode_valid && !result.registers_valid,
		"entry fields on a miss")

endmodule
